### src/p2sa_pkg.sv
`timescale 1ns / 1ps

package p2sa_pkg;

    localparam int unsigned HDR_BYTES  = 16;
    localparam int unsigned GRAN_SHIFT = 5;

    localparam int unsigned LEN_W  = 24;
    localparam int unsigned PSLOT_W = 15;
    localparam int unsigned COPY_W = 20;

    typedef enum logic [1:0] {
        ACT_ALLOC  = 2'd0,
        ACT_FREE   = 2'd1,
        ACT_RESIZE = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

endpackage

### src/p2sa_ram.sv
`timescale 1ns / 1ps

module p2sa_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/pow2_bucket_slab_allocator.sv
`timescale 1ns / 1ps

// Power-of-two slab allocator over 2^(NUM_CLASSES-1) granules of 32 bytes, one
// LIFO free list per class, no coalescing. One request is in flight at a time:
// a free of a present block or an in-place resize reads the class and size
// memories and then pushes or rewrites; an allocate searches for a class, reads
// the link memory, pops the head and runs the split loop, which writes one free
// half per cycle; a moving resize adds the read of the old block and its free
// to the allocate it contains. Reads of the link, class and size memories are
// registered. The result sits in an output register; no clearing pass is needed after reset.
module pow2_bucket_slab_allocator #(
    parameter int unsigned NUM_CLASSES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    action,
    input  logic [p2sa_pkg::LEN_W-1:0]    request_length,
    input  logic                          block_present,
    input  logic [p2sa_pkg::PSLOT_W-1:0]  block_slot,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          status,
    output logic                          result_present,
    output logic [p2sa_pkg::PSLOT_W-1:0]  result_slot,
    output logic [p2sa_pkg::COPY_W-1:0]   copy_bytes
);

    import p2sa_pkg::*;

    localparam int unsigned SW    = NUM_CLASSES - 1;
    localparam int unsigned DEPTH = 1 << SW;
    localparam int unsigned CW    = $clog2(NUM_CLASSES);

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_RD, S_FREE_PUSH, S_RS_EVAL, S_AL_SRCH, S_AL_RD,
        S_AL_POP, S_AL_SPLIT, S_AL_WR, S_MV_FREE, S_DONE
    } state_t;

    state_t state_reg;

    logic [1:0]       act_reg;
    logic [LEN_W-1:0] len_reg;
    logic             pres_reg;
    logic [SW-1:0]    slot_reg;
    logic [CW-1:0]    cls_reg;
    logic             fits_reg;
    logic [CW-1:0]    k_reg;
    logic [SW-1:0]    up_reg;
    logic             move_reg;
    logic             err_reg;
    logic [CW-1:0]    oldcls_reg;
    logic [LEN_W-1:0] oldsize_reg;
    logic             link0_wr_reg;

    logic [SW-1:0]    head_slot_reg [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] head_valid_reg;

    logic             ovalid_reg;
    logic             ostatus_reg;
    logic             opres_reg;
    logic [SW-1:0]    oslot_reg;
    logic [COPY_W-1:0] ocopy_reg;

    logic             rstatus_reg;
    logic             rpres_reg;
    logic [SW-1:0]    rslot_reg;
    logic [COPY_W-1:0] rcopy_reg;

    logic             link_we;
    logic [SW-1:0]    link_waddr;
    logic [SW:0]      link_wdata;
    logic [SW:0]      link_rdata;
    logic             cls_we;
    logic [SW-1:0]    cls_waddr;
    logic [CW-1:0]    cls_wdata;
    logic [CW-1:0]    cls_rdata;
    logic             size_we;
    logic [LEN_W-1:0] size_wdata;
    logic [LEN_W-1:0] size_rdata;

    logic [LEN_W:0]   need;
    logic [CW-1:0]    need_cls;
    logic             need_fits;
    logic [CW-1:0]    srch_k;
    logic             srch_hit;
    logic [SW:0]      link_eff;
    logic [CW-1:0]    k_dec;
    logic [SW-1:0]    split_other;
    logic [CW-1:0]    shr_cls;
    logic [SW-1:0]    shr_other;
    logic [CW-1:0]    mv_cls;
    logic [LEN_W-1:0] mv_old;
    logic [LEN_W-1:0] mv_copy;
    logic             in_xfer;

    assign in_xfer  = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);

    assign out_valid      = ovalid_reg;
    assign status         = ostatus_reg;
    assign result_present = opres_reg;
    assign result_slot    = PSLOT_W'(oslot_reg);
    assign copy_bytes     = ocopy_reg;

    // size class that holds length plus header
    assign need = (LEN_W+1)'(len_reg) + (LEN_W+1)'(HDR_BYTES);

    always_comb
    begin
        need_cls  = '0;
        need_fits = 1'b0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--)
        begin
            if (64'(need) <= (64'd1 << (c + GRAN_SHIFT)))
            begin
                need_cls  = CW'(c);
                need_fits = 1'b1;
            end
        end
    end

    // nearest non-empty class at or above the needed one
    always_comb
    begin
        srch_k   = '0;
        srch_hit = 1'b0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--)
        begin
            if (head_valid_reg[c] && (CW'(c) >= cls_reg))
            begin
                srch_k   = CW'(c);
                srch_hit = 1'b1;
            end
        end
    end

    assign link_eff    = ((up_reg == '0) && !link0_wr_reg) ? '0 : link_rdata;
    assign k_dec       = k_reg - CW'(1);
    assign split_other = up_reg + (SW'(1) << k_dec);
    assign shr_cls     = cls_rdata - CW'(1);
    assign shr_other   = slot_reg + (SW'(1) << shr_cls);
    assign mv_cls      = (up_reg == slot_reg) ? cls_reg : oldcls_reg;
    assign mv_old      = (up_reg == slot_reg) ? len_reg : oldsize_reg;
    assign mv_copy     = (mv_old < len_reg) ? mv_old : len_reg;

    always_comb
    begin
        link_we    = 1'b0;
        link_waddr = slot_reg;
        link_wdata = '0;
        cls_we     = 1'b0;
        cls_waddr  = slot_reg;
        cls_wdata  = cls_reg;
        size_we    = 1'b0;
        size_wdata = len_reg;
        unique case (state_reg)
            S_FREE_PUSH:
            begin
                if (32'(cls_rdata) < NUM_CLASSES)
                begin
                    link_we    = 1'b1;
                    link_wdata = {head_valid_reg[cls_rdata], head_slot_reg[cls_rdata]};
                end
            end
            S_RS_EVAL:
            begin
                if (fits_reg && (cls_rdata != '0) && (32'(cls_rdata) < NUM_CLASSES)
                    && (cls_reg < cls_rdata))
                begin
                    link_we    = 1'b1;
                    link_waddr = shr_other;
                    link_wdata = {head_valid_reg[shr_cls], head_slot_reg[shr_cls]};
                    cls_we     = 1'b1;
                    cls_wdata  = shr_cls;
                    size_we    = 1'b1;
                end
                else if (fits_reg && (32'(cls_rdata) < NUM_CLASSES)
                         && (cls_reg <= cls_rdata))
                begin
                    size_we = 1'b1;
                end
            end
            S_AL_SPLIT:
            begin
                link_we    = 1'b1;
                link_waddr = split_other;
                link_wdata = '0;
            end
            S_AL_WR:
            begin
                cls_we    = 1'b1;
                cls_waddr = up_reg;
                size_we   = 1'b1;
            end
            S_MV_FREE:
            begin
                if (32'(mv_cls) < NUM_CLASSES)
                begin
                    link_we    = 1'b1;
                    link_wdata = {head_valid_reg[mv_cls], head_slot_reg[mv_cls]};
                end
            end
            default:
            begin
            end
        endcase
    end

    p2sa_ram #(.WIDTH(SW + 1), .DEPTH(DEPTH)) u_link (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (head_slot_reg[k_reg]),
        .rdata (link_rdata)
    );

    p2sa_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_class (
        .clk   (clk),
        .we    (cls_we),
        .waddr (cls_waddr),
        .wdata (cls_wdata),
        .raddr (slot_reg),
        .rdata (cls_rdata)
    );

    p2sa_ram #(.WIDTH(LEN_W), .DEPTH(DEPTH)) u_size (
        .clk   (clk),
        .we    (size_we),
        .waddr (cls_waddr),
        .wdata (size_wdata),
        .raddr (slot_reg),
        .rdata (size_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ovalid_reg     <= 1'b0;
            link0_wr_reg   <= 1'b0;
            head_valid_reg <= NUM_CLASSES'(1) << (NUM_CLASSES - 1);
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                head_slot_reg[c] <= '0;
            end
        end
        else
        begin
            if (ovalid_reg && !out_stall && (state_reg != S_DONE))
            begin
                ovalid_reg <= 1'b0;
            end
            if (link_we && (link_waddr == '0))
            begin
                link0_wr_reg <= 1'b1;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        act_reg   <= action;
                        len_reg   <= request_length;
                        pres_reg  <= block_present;
                        slot_reg  <= SW'(block_slot);
                        state_reg <= S_DEC;
                    end
                end
                S_DEC:
                begin
                    cls_reg     <= need_cls;
                    fits_reg    <= need_fits;
                    move_reg    <= 1'b0;
                    rstatus_reg <= 1'b0;
                    rpres_reg   <= 1'b0;
                    rslot_reg   <= '0;
                    rcopy_reg   <= '0;
                    err_reg     <= (len_reg == '0);
                    priority case (action_t'(act_reg))
                        ACT_ALLOC:
                        begin
                            if ((len_reg == '0) || !need_fits)
                            begin
                                rstatus_reg <= 1'b1;
                                state_reg   <= S_DONE;
                            end
                            else
                            begin
                                state_reg <= S_AL_SRCH;
                            end
                        end
                        ACT_FREE:
                        begin
                            state_reg <= pres_reg ? S_RD : S_DONE;
                        end
                        ACT_RESIZE:
                        begin
                            if (len_reg == '0)
                            begin
                                rstatus_reg <= 1'b1;
                                state_reg   <= pres_reg ? S_RD : S_DONE;
                            end
                            else if (pres_reg)
                            begin
                                state_reg <= S_RD;
                            end
                            else if (!need_fits)
                            begin
                                rstatus_reg <= 1'b1;
                                state_reg   <= S_DONE;
                            end
                            else
                            begin
                                state_reg <= S_AL_SRCH;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_RD:
                begin
                    state_reg <= (act_reg == ACT_FREE || err_reg) ? S_FREE_PUSH : S_RS_EVAL;
                end
                S_FREE_PUSH:
                begin
                    if (32'(cls_rdata) < NUM_CLASSES)
                    begin
                        head_slot_reg[cls_rdata]  <= slot_reg;
                        head_valid_reg[cls_rdata] <= 1'b1;
                    end
                    state_reg <= S_DONE;
                end
                S_RS_EVAL:
                begin
                    oldcls_reg  <= cls_rdata;
                    oldsize_reg <= size_rdata;
                    if (fits_reg && (cls_rdata != '0) && (32'(cls_rdata) < NUM_CLASSES)
                        && (cls_reg < cls_rdata))
                    begin
                        head_slot_reg[shr_cls]  <= shr_other;
                        head_valid_reg[shr_cls] <= 1'b1;
                        rpres_reg <= 1'b1;
                        rslot_reg <= slot_reg;
                        state_reg <= S_DONE;
                    end
                    else if (fits_reg && (32'(cls_rdata) < NUM_CLASSES)
                             && (cls_reg <= cls_rdata))
                    begin
                        rpres_reg <= 1'b1;
                        rslot_reg <= slot_reg;
                        state_reg <= S_DONE;
                    end
                    else if (!fits_reg)
                    begin
                        rstatus_reg <= 1'b1;
                        state_reg   <= S_DONE;
                    end
                    else
                    begin
                        move_reg  <= 1'b1;
                        state_reg <= S_AL_SRCH;
                    end
                end
                S_AL_SRCH:
                begin
                    if (srch_hit)
                    begin
                        k_reg     <= srch_k;
                        state_reg <= S_AL_RD;
                    end
                    else
                    begin
                        rstatus_reg <= 1'b1;
                        state_reg   <= S_DONE;
                    end
                end
                S_AL_RD:
                begin
                    up_reg    <= head_slot_reg[k_reg];
                    state_reg <= S_AL_POP;
                end
                S_AL_POP:
                begin
                    head_slot_reg[k_reg]  <= link_eff[SW-1:0];
                    head_valid_reg[k_reg] <= link_eff[SW];
                    state_reg <= (k_reg == cls_reg) ? S_AL_WR : S_AL_SPLIT;
                end
                S_AL_SPLIT:
                begin
                    head_slot_reg[k_dec]  <= split_other;
                    head_valid_reg[k_dec] <= 1'b1;
                    k_reg <= k_dec;
                    if (k_dec == cls_reg)
                    begin
                        state_reg <= S_AL_WR;
                    end
                end
                S_AL_WR:
                begin
                    rpres_reg <= 1'b1;
                    rslot_reg <= up_reg;
                    state_reg <= move_reg ? S_MV_FREE : S_DONE;
                end
                S_MV_FREE:
                begin
                    if (32'(mv_cls) < NUM_CLASSES)
                    begin
                        head_slot_reg[mv_cls]  <= slot_reg;
                        head_valid_reg[mv_cls] <= 1'b1;
                    end
                    rcopy_reg <= mv_copy[COPY_W-1:0];
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!ovalid_reg || !out_stall)
                    begin
                        ovalid_reg  <= 1'b1;
                        ostatus_reg <= rstatus_reg;
                        opres_reg   <= rpres_reg;
                        oslot_reg   <= rslot_reg;
                        ocopy_reg   <= rcopy_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_split_above: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_AL_SPLIT) |-> (k_reg > cls_reg))
        else $error("split below requested class");

    a_present_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_present |-> !status)
        else $error("returned block with error status");

    a_copy_move: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (copy_bytes != '0) |-> result_present)
        else $error("copy length without block");

    a_accept_dec: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == S_DEC))
        else $error("transfer not decoded");

endmodule
